[rtl/ils_pkg.sv]
// Shared types, codes and widths for the indexed list store.
package ils_pkg;

   localparam int CAPACITY_DEFAULT = 16;

   localparam int KIND_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 6;
   localparam int FOUND_W  = 5;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD    = 2'd0,
      KIND_FIND   = 2'd1,
      KIND_GET    = 2'd2,
      KIND_REMOVE = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_NOTFOUND = 2'd1,
      STAT_RANGE    = 2'd2,
      STAT_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_DATA = 2'd2
   } state_type;

endpackage

[rtl/ils_ifs.sv]
// Request and response channel interfaces of the indexed list store.
interface ils_req_if;
   logic                            valid;
   logic                            ready;
   ils_pkg::kind_type               kind;
   logic signed [ils_pkg::VALUE_W-1:0] value;
   logic [ils_pkg::POS_W-1:0]       position;

   modport source (output valid, output kind, output value, output position, input ready);
   modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

interface ils_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [ils_pkg::FOUND_W-1:0] found_position;
   logic signed [ils_pkg::VALUE_W-1:0] read_value;
   logic [ils_pkg::COUNT_W-1:0]        entry_count;
   ils_pkg::status_type                status;

   modport source (output valid, output found_position, output read_value,
                   output entry_count, output status, input ready);
   modport sink   (input valid, input found_position, input read_value,
                   input entry_count, input status, output ready);
endinterface

[rtl/indexed_list_store.sv]
// Top level of the indexed list store: sequencer, entry RAM and response register.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit entries in a
// single RAM (one write port, one registered read port) and serves one request
// at a time. Add puts a value at the front, find returns the first matching
// position (or -1), get reads the entry at a position (or 0), and remove
// deletes an entry and closes the gap; every response carries the entry count
// afterward and a status. Each moved or inspected entry takes a RAM read and
// then a write or compare in the one shared datapath; an add moves every stored
// entry back, a find walks from the front until a match, a get reads one entry,
// and a remove moves each entry behind position p forward. Refused requests
// (full list, position out of range) respond without touching the RAM. The
// request side is ready only while the sequencer is idle. The response sits in
// an output register, so a new request is taken while it waits; the next
// response stalls the sequencer until the register frees. The RAM needs no
// clearing pass: entries at or past the count are never read.
module indexed_list_store #(
   parameter int CAPACITY = ils_pkg::CAPACITY_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   ils_req_if.sink   req_chan,
   ils_rsp_if.source rsp_chan
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > ils_pkg::POS_W) ? CNT_W : ils_pkg::POS_W;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // Sequencer state and latched request
   ils_pkg::state_type                 state_ff, state_in;
   ils_pkg::kind_type                  kind_ff;
   logic signed [ils_pkg::VALUE_W-1:0] value_ff;
   logic [ils_pkg::POS_W-1:0]          pos_ff;
   logic [CNT_W-1:0]                   idx_ff, idx_in;
   logic [CNT_W-1:0]                   count_ff, count_in;

   // Response register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [ils_pkg::FOUND_W-1:0] rsp_found_ff;
   logic signed [ils_pkg::VALUE_W-1:0] rsp_read_ff;
   logic [ils_pkg::COUNT_W-1:0]        rsp_count_ff;
   ils_pkg::status_type                rsp_status_ff;

   // Step results
   logic                               done, go_data, out_free, req_accept;
   logic signed [ils_pkg::FOUND_W-1:0] res_found;
   logic signed [ils_pkg::VALUE_W-1:0] res_read;
   ils_pkg::status_type                res_status;

   // RAM control
   logic                        wr_en, rd_en;
   logic [ADDR_W-1:0]           wr_addr, rd_addr;
   logic [ils_pkg::VALUE_W-1:0] wr_data, rd_data;

   logic [CNT_W-1:0] idx_nx, idx_pv;
   logic [CMP_W-1:0] pos_ext, cnt_ext, idx_ext, cnt_res_ext;
   logic             pos_ok, data_hit;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;

   assign idx_nx   = CNT_W'(idx_ff + 1'b1);
   assign idx_pv   = CNT_W'(idx_ff - 1'b1);
   assign pos_ext  = CMP_W'(pos_ff);
   assign cnt_ext  = CMP_W'(count_ff);
   assign idx_ext  = CMP_W'(idx_ff);
   assign pos_ok   = pos_ext < cnt_ext;
   // the one shared compare: RAM word against the searched value
   assign data_hit = (rd_data == value_ff);

   ils_ram #(
      .WIDTH (ils_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Datapath step: decide what this cycle does to the RAM, the index and count
   always_comb begin
      done       = 1'b0;
      go_data    = 1'b0;
      idx_in     = idx_ff;
      count_in   = count_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff[ADDR_W-1:0];
      wr_data    = rd_data;
      rd_en      = 1'b0;
      rd_addr    = idx_ff[ADDR_W-1:0];
      res_found  = '1;
      res_read   = '0;
      res_status = ils_pkg::STAT_OK;
      case (state_ff)
         ils_pkg::ST_IDLE: begin
            // seed the walk index from the incoming request
            if (req_accept) begin
               case (req_chan.kind)
                  ils_pkg::KIND_ADD:  idx_in = count_ff;
                  ils_pkg::KIND_FIND: idx_in = '0;
                  default:            idx_in = CNT_W'(req_chan.position);
               endcase
            end
         end
         ils_pkg::ST_SCAN: begin
            case (kind_ff)
               ils_pkg::KIND_ADD: begin
                  if (count_ff == CAP_CNT) begin
                     done       = 1'b1;
                     res_status = ils_pkg::STAT_FULL;
                  end else if (idx_ff == '0) begin
                     // slot 0 is free now: drop the new value in
                     done = 1'b1;
                     if (out_free) begin
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        wr_data  = value_ff;
                        count_in = CNT_W'(count_ff + 1'b1);
                     end
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = idx_pv[ADDR_W-1:0];
                     go_data = 1'b1;
                  end
               end
               ils_pkg::KIND_FIND: begin
                  if (idx_ff == count_ff) begin
                     done       = 1'b1;
                     res_status = ils_pkg::STAT_NOTFOUND;
                  end else begin
                     rd_en   = 1'b1;
                     go_data = 1'b1;
                  end
               end
               ils_pkg::KIND_GET: begin
                  if (!pos_ok) begin
                     done       = 1'b1;
                     res_status = ils_pkg::STAT_RANGE;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = pos_ext[ADDR_W-1:0];
                     go_data = 1'b1;
                  end
               end
               default: begin
                  if (!pos_ok) begin
                     done       = 1'b1;
                     res_status = ils_pkg::STAT_RANGE;
                  end else if (idx_nx == count_ff) begin
                     // gap has reached the tail
                     done = 1'b1;
                     if (out_free) begin
                        count_in = CNT_W'(count_ff - 1'b1);
                     end
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = idx_nx[ADDR_W-1:0];
                     go_data = 1'b1;
                  end
               end
            endcase
         end
         ils_pkg::ST_DATA: begin
            case (kind_ff)
               ils_pkg::KIND_ADD: begin
                  // move entry idx-1 back to idx
                  wr_en  = 1'b1;
                  idx_in = idx_pv;
               end
               ils_pkg::KIND_FIND: begin
                  if (data_hit) begin
                     done      = 1'b1;
                     res_found = idx_ext[ils_pkg::FOUND_W-1:0];
                  end else begin
                     idx_in = idx_nx;
                  end
               end
               ils_pkg::KIND_GET: begin
                  done     = 1'b1;
                  res_read = rd_data;
               end
               default: begin
                  // move entry idx+1 forward to idx
                  wr_en  = 1'b1;
                  idx_in = idx_nx;
               end
            endcase
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ils_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = ils_pkg::ST_SCAN;
            end
         end
         ils_pkg::ST_SCAN: begin
            if (done) begin
               if (out_free) begin
                  state_in = ils_pkg::ST_IDLE;
               end
            end else if (go_data) begin
               state_in = ils_pkg::ST_DATA;
            end
         end
         ils_pkg::ST_DATA: begin
            if (done) begin
               if (out_free) begin
                  state_in = ils_pkg::ST_IDLE;
               end
            end else begin
               state_in = ils_pkg::ST_SCAN;
            end
         end
         default: state_in = ils_pkg::ST_IDLE;
      endcase
   end

   // Response valid: set on a finished request, clear once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign cnt_res_ext = CMP_W'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ils_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (req_accept) begin
         kind_ff  <= req_chan.kind;
         value_ff <= req_chan.value;
         pos_ff   <= req_chan.position;
      end
      // hold the payload until a finished request can land
      if (done && out_free) begin
         rsp_found_ff  <= res_found;
         rsp_read_ff   <= res_read;
         rsp_count_ff  <= cnt_res_ext[ils_pkg::COUNT_W-1:0];
         rsp_status_ff <= res_status;
      end
   end

   assign req_chan.ready          = (state_ff == ils_pkg::ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.found_position = rsp_found_ff;
   assign rsp_chan.read_value     = rsp_read_ff;
   assign rsp_chan.entry_count    = rsp_count_ff;
   assign rsp_chan.status         = rsp_status_ff;

endmodule

[rtl/ils_ram.sv]
// Generic simple dual-port RAM with registered read.
module ils_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ils_checker.sv]
// Port-level assertions for the indexed list store, bound to the top level.
module ils_checker #(
   parameter int CAPACITY = ils_pkg::CAPACITY_DEFAULT
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [ils_pkg::FOUND_W-1:0] found_position,
   input logic signed [ils_pkg::VALUE_W-1:0] read_value,
   input logic [ils_pkg::COUNT_W-1:0]        entry_count,
   input ils_pkg::status_type                status
);

   localparam logic [ils_pkg::COUNT_W-1:0] CAP_LOW = ils_pkg::COUNT_W'(CAPACITY);

   // a response stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // one request at a time: no request taken right after another
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request side ready right after an accepted request");

   // a full status comes with the count at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ils_pkg::STAT_FULL |-> entry_count == CAP_LOW)
      else $error("full status with count below capacity");

   // only a successful get returns data, a miss reports no position
   a_unused_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ils_pkg::STAT_OK |->
         read_value == '0 && found_position == '1)
      else $error("unused response fields not at their idle values");

   // count stays within capacity (checked only for CAPACITY up to 16)
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CAPACITY > 16) || (entry_count <= CAP_LOW))
      else $error("entry count beyond capacity");

endmodule

bind indexed_list_store ils_checker #(
   .CAPACITY (CAPACITY)
) u_ils_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .found_position (rsp_chan.found_position),
   .read_value     (rsp_chan.read_value),
   .entry_count    (rsp_chan.entry_count),
   .status         (rsp_chan.status)
);

[test/testbench.sv]
// Self-checking testbench for the indexed list store: shadow list, mixed requests, random stalls.

typedef struct packed {
   logic signed [ils_pkg::FOUND_W-1:0] found_position;
   logic signed [ils_pkg::VALUE_W-1:0] read_value;
   logic [ils_pkg::COUNT_W-1:0]        entry_count;
   ils_pkg::status_type                status;
} list_reply_type;

class list_shadow_type;
   logic signed [ils_pkg::VALUE_W-1:0] cells [ils_pkg::CAPACITY_DEFAULT];
   int             fill;
   list_reply_type due_replies [$];

   function new();
      fill = 0;
   endfunction

   function int stored();
      return fill;
   endfunction

   function logic signed [ils_pkg::VALUE_W-1:0] cell_at(int idx);
      return cells[idx];
   endfunction

   function int outstanding();
      return due_replies.size();
   endfunction

   // Apply one accepted request to the shadow list and queue the reply it owes.
   function void take_request(ils_pkg::kind_type kind,
                              logic signed [ils_pkg::VALUE_W-1:0] value,
                              logic [ils_pkg::POS_W-1:0] position);
      list_reply_type r;
      int             i;
      bit             hit;
      r.found_position = '1;
      r.read_value     = '0;
      r.status         = ils_pkg::STAT_OK;
      hit              = 1'b0;
      case (kind)
         ils_pkg::KIND_ADD: begin
            if (fill >= ils_pkg::CAPACITY_DEFAULT) begin
               r.status = ils_pkg::STAT_FULL;
            end else begin
               for (i = fill; i > 0; i--) cells[i] = cells[i-1];
               cells[0] = value;
               fill++;
            end
         end
         ils_pkg::KIND_FIND: begin
            for (i = 0; i < fill; i++) begin
               if (!hit && cells[i] == value) begin
                  hit = 1'b1;
                  r.found_position = i[ils_pkg::FOUND_W-1:0];
               end
            end
            if (!hit) r.status = ils_pkg::STAT_NOTFOUND;
         end
         ils_pkg::KIND_GET: begin
            if (int'(position) < fill) r.read_value = cells[position];
            else r.status = ils_pkg::STAT_RANGE;
         end
         default: begin
            if (int'(position) >= fill) begin
               r.status = ils_pkg::STAT_RANGE;
            end else begin
               for (i = int'(position); i < fill - 1; i++) cells[i] = cells[i+1];
               fill--;
            end
         end
      endcase
      r.entry_count = fill[ils_pkg::COUNT_W-1:0];
      due_replies.push_back(r);
   endfunction

   // Compare a reply with the oldest one owed; empty string means it matched.
   function string match_reply(list_reply_type got);
      list_reply_type want;
      string          diff;
      diff = "";
      if (due_replies.size() == 0)
         return $sformatf("reply with none owed: found %0d read %0d count %0d status %0d",
                          got.found_position, got.read_value, got.entry_count, got.status);
      want = due_replies.pop_front();
      if (got.found_position !== want.found_position)
         diff = {diff, $sformatf(" found_position %0d/%0d", got.found_position,
                                 want.found_position)};
      if (got.read_value !== want.read_value)
         diff = {diff, $sformatf(" read_value %0d/%0d", got.read_value, want.read_value)};
      if (got.entry_count !== want.entry_count)
         diff = {diff, $sformatf(" entry_count %0d/%0d", got.entry_count, want.entry_count)};
      if (got.status !== want.status)
         diff = {diff, $sformatf(" status %0d/%0d", got.status, want.status)};
      if (diff != "") diff = {"got/expected:", diff};
      return diff;
   endfunction
endclass

module testbench;

   localparam int GAP_MAX      = 16;
   localparam int RANDOM_ITEMS = 600;
   localparam int CALM_ITEMS   = 80;
   // drain wait after the last reply: leaves room for a stray reply
   localparam int DRAIN_CYCLES = 4 * ils_pkg::CAPACITY_DEFAULT;

   logic clock = 1'b0;
   logic reset;

   ils_req_if req_chan ();
   ils_rsp_if rsp_chan ();

   indexed_list_store DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   list_shadow_type shadow = new();
   int              failures = 0;
   int              requests_taken = 0;
   int              replies_taken = 0;
   bit              calm = 1'b0;

   always #2 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      failures++;
   endtask

   // Watch both channels at each rising edge. Check the reply first, then
   // record the request, so a reply never pairs with a request of the same edge.
   always @(posedge clock) begin
      list_reply_type got;
      string          verdict;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.found_position = rsp_chan.found_position;
            got.read_value     = rsp_chan.read_value;
            got.entry_count    = rsp_chan.entry_count;
            got.status         = rsp_chan.status;
            verdict = shadow.match_reply(got);
            if (verdict != "") report_mismatch(verdict);
            replies_taken++;
         end
         if (req_chan.valid && req_chan.ready) begin
            shadow.take_request(req_chan.kind, req_chan.value, req_chan.position);
            requests_taken++;
         end
      end
   end

   // Stall the reply side in bursts; hold ready high through the calm tail.
   initial begin
      rsp_chan.ready <= 1'b1;
      forever begin
         repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 20)) @(posedge clock);
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Present one request and hold it until the monitor has taken it. The wait
   // returns in the acceptance step, after the shadow list has been updated.
   task automatic send(ils_pkg::kind_type k, logic signed [ils_pkg::VALUE_W-1:0] v,
                       logic [ils_pkg::POS_W-1:0] p);
      int target;
      target = requests_taken + 1;
      req_chan.valid    <= 1'b1;
      req_chan.kind     <= k;
      req_chan.value    <= v;
      req_chan.position <= p;
      wait (requests_taken == target);
   endtask

   // Drop valid for a random burst now and then; never in the calm tail.
   task automatic maybe_idle();
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, GAP_MAX)) @(posedge clock);
      end
   endtask

   // Drop valid and hold off until every owed reply has come back.
   task automatic hold_until_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (replies_taken == requests_taken);
   endtask

   initial begin
      logic signed [ils_pkg::VALUE_W-1:0] seed_values [16];
      logic signed [ils_pkg::VALUE_W-1:0] value_pool [8];
      logic signed [ils_pkg::VALUE_W-1:0] v;
      logic [ils_pkg::POS_W-1:0]          p;
      ils_pkg::kind_type                  k;
      int                                 n;
      int                                 roll;
      bit                                 filling;

      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.kind     <= ils_pkg::KIND_ADD;
      req_chan.value    <= '0;
      req_chan.position <= '0;

      // oldest add ends up at the back: min lands at 15, max at 0,
      // and the two sevens sit at 12 and 5 so find must pick the front one
      seed_values = '{32'sh8000_0000, 32'sd0, -32'sd1, 32'sd7, 32'sd1, 32'sh5555_5555,
                      32'shAAAA_AAAA, 32'sd100, -32'sd100, 32'sd3, 32'sd7, 32'sd42,
                      32'sh0F0F_0F0F, -32'sd2, 32'sd2, 32'sh7FFF_FFFF};
      value_pool  = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1,
                      $urandom, $urandom, $urandom, $urandom};
      filling = 1'b1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty list: find misses, get and remove are out of range
      send(ils_pkg::KIND_FIND, 32'sd5, 6'd0);
      send(ils_pkg::KIND_GET, 32'sd0, 6'd0);
      send(ils_pkg::KIND_REMOVE, 32'sd0, 6'd0);
      // fill to capacity, then one add too many
      for (n = 0; n < ils_pkg::CAPACITY_DEFAULT; n++) begin
         send(ils_pkg::KIND_ADD, seed_values[n], ils_pkg::POS_W'($urandom_range(0, 63)));
         maybe_idle();
      end
      send(ils_pkg::KIND_ADD, 32'sd99, 6'd63);
      // find at the back, first of two matches, and a miss on a full list
      send(ils_pkg::KIND_FIND, 32'sh8000_0000, 6'd0);
      send(ils_pkg::KIND_FIND, 32'sd7, 6'd0);
      send(ils_pkg::KIND_FIND, 32'sd12345, 6'd0);
      // reads at the last slot and far past the end
      send(ils_pkg::KIND_GET, 32'sd0, 6'd15);
      send(ils_pkg::KIND_GET, 32'sd0, 6'd63);
      // removes past the end, at the back and at the front
      send(ils_pkg::KIND_REMOVE, 32'sd0, 6'd63);
      send(ils_pkg::KIND_REMOVE, 32'sd0, 6'd15);
      send(ils_pkg::KIND_REMOVE, 32'sd0, 6'd0);
      send(ils_pkg::KIND_GET, 32'sd0, 6'd0);
      hold_until_drained();

      // Random part: swing between filling and draining so the count walks
      // the whole range, with values drawn mostly from a small pool so finds hit.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         if (n == RANDOM_ITEMS / 2) hold_until_drained();
         if ($urandom_range(0, 29) == 0) filling = !filling;
         roll = $urandom_range(0, 99);
         if (filling)
            k = (roll < 45) ? ils_pkg::KIND_ADD : (roll < 65) ? ils_pkg::KIND_FIND :
                (roll < 85) ? ils_pkg::KIND_GET : ils_pkg::KIND_REMOVE;
         else
            k = (roll < 15) ? ils_pkg::KIND_ADD : (roll < 35) ? ils_pkg::KIND_FIND :
                (roll < 55) ? ils_pkg::KIND_GET : ils_pkg::KIND_REMOVE;
         roll = $urandom_range(0, 9);
         if (k == ils_pkg::KIND_FIND && shadow.stored() > 0 && roll < 4)
            v = shadow.cell_at($urandom_range(0, shadow.stored() - 1));
         else if (roll < 7)
            v = value_pool[$urandom_range(0, 7)];
         else
            v = $urandom;
         if ($urandom_range(0, 4) == 0) p = ils_pkg::POS_W'($urandom_range(0, 63));
         else p = ils_pkg::POS_W'($urandom_range(0, shadow.stored()));
         send(k, v, p);
         maybe_idle();
      end

      req_chan.valid <= 1'b0;
      wait (replies_taken == requests_taken);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.outstanding() != 0)
         report_mismatch($sformatf("%0d replies never arrived", shadow.outstanding()));
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Hang guard: far beyond the slowest legal run of this stimulus.
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
